@@ hdl/tmb_pkg.sv @@
// Package: shared types, codes and defaults of the timer bank.
`timescale 1ns / 1ps
package tmb_pkg;

   localparam int NUM_TIMERS_DEFAULT = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [3:0] OP_ALLOC_PER  = 4'd0;
   localparam logic [3:0] OP_ALLOC_ONE  = 4'd1;
   localparam logic [3:0] OP_START      = 4'd2;
   localparam logic [3:0] OP_STOP       = 4'd3;
   localparam logic [3:0] OP_FREE       = 4'd4;
   localparam logic [3:0] OP_SET_IVL    = 4'd5;
   localparam logic [3:0] OP_QUERY      = 4'd6;
   localparam logic [3:0] OP_TICK       = 4'd7;
   localparam logic [3:0] OP_READ_STAT  = 4'd8;
   localparam logic [3:0] OP_CLEAR_STAT = 4'd9;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SLOT  = 2'd1;
   localparam logic [1:0] ST_ZERO_IVL = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   localparam logic [1:0] EV_REPLY = 2'd0;
   localparam logic [1:0] EV_FIRED = 2'd1;
   localparam logic [1:0] EV_TICK  = 2'd2;

   localparam logic [1:0] SEL_CREATED = 2'd0;
   localparam logic [1:0] SEL_RUNNING = 2'd1;
   localparam logic [1:0] SEL_FIRES   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_STAT_EN = 3'd0;

   localparam logic [4:0] RUN_MAX = 5'd31;

   typedef struct packed {
      logic        allocated;
      logic        running;
      logic        periodic;
      logic [31:0] interval;
      logic [63:0] deadline;
   } slot_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

@@ hdl/tmb_cell.sv @@
// One timer slot cell of the rotating slot ring.
`timescale 1ns / 1ps
module tmb_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tmb_pkg::slot_type  slot_d,
   output tmb_pkg::slot_type  slot_q
);
   tmb_pkg::slot_type slot_ff;
   tmb_pkg::slot_type slot_in;

   always_comb begin
      slot_in = shift ? slot_d : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;
endmodule

@@ hdl/multi_channel_timer_bank.sv @@
// Top level: command decode, slot ring scan, statistics and result register.
//
// A bank of NUM_TIMERS microsecond timers. Slot state lives in a ring of
// cells that rotates by one cell per cycle during a scan, unless a tick holds
// it; the slot at the ring's head is read, updated and written back into the
// ring's tail. Commands that address slots (alloc, start, stop, free, set
// interval, query, tick) accept the beat, scan one full rotation of
// NUM_TIMERS cells, and then load the reply beat. Read stat, clear stats,
// unknown opcodes and an alloc with a zero interval skip the scan. A tick
// emits one fired beat per due slot as the slot passes the head, and the
// rotation holds while a due slot meets an occupied result register; the
// reply beat likewise waits for a free result register. One command is
// handled at a time; req_ready is high between commands.
`timescale 1ns / 1ps
module multi_channel_timer_bank #(
   parameter int NUM_TIMERS = tmb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_opcode,
   input  logic [3:0]                     req_timer_index,
   input  logic [31:0]                    req_interval_us,
   input  logic [15:0]                    req_advance_us,
   input  logic [1:0]                     req_stat_select,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_event_kind,
   output logic [3:0]                     rsp_result_index,
   output logic                           rsp_is_active,
   output logic [63:0]                    rsp_result_value,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tmb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
   localparam logic [IDX_W-1:0] LAST_K = IDX_W'(NUM_TIMERS - 1);

   // slot ring
   tmb_pkg::slot_type chain_q [NUM_TIMERS];
   tmb_pkg::slot_type wb;
   tmb_pkg::slot_type head;
   logic              step;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      tmb_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (step),
         .slot_d ((g == 0) ? wb : chain_q[(g == 0) ? 0 : g - 1]),
         .slot_q (chain_q[g])
      );
   end

   assign head = chain_q[NUM_TIMERS-1];

   // control and command registers
   tmb_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [3:0]         op_ff, op_in;
   logic [3:0]         ti_ff, ti_in;
   logic [31:0]        iv_ff, iv_in;
   logic               found_ff, found_in;
   logic [63:0]        now_ff, now_in;
   logic [31:0]        created_ff, created_in;
   logic [4:0]         running_ff, running_in;
   logic [31:0]        fires_ff, fires_in;
   logic               stat_en_ff, stat_en_in;

   // pending reply
   logic [1:0]  rep_status_ff, rep_status_in;
   logic [1:0]  rep_kind_ff, rep_kind_in;
   logic [3:0]  rep_index_ff, rep_index_in;
   logic        rep_active_ff, rep_active_in;
   logic [63:0] rep_value_ff, rep_value_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_active_ff, rsp_active_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   logic out_free;
   logic accept;
   logic hit;
   logic due;
   logic csr_wr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == tmb_pkg::S_IDLE);
   assign accept = req_valid && req_ready;
   assign hit = (CMP_W'(k_ff) == CMP_W'(ti_ff)) && head.allocated;
   assign due = head.allocated && head.running && (now_ff >= head.deadline);
   assign csr_wr = psel && penable && pwrite && (paddr == tmb_pkg::REG_STAT_EN);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmb_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  tmb_pkg::OP_ALLOC_PER, tmb_pkg::OP_ALLOC_ONE: begin
                     state_in = (req_interval_us == 32'd0) ? tmb_pkg::S_DONE
                                                           : tmb_pkg::S_SCAN;
                  end
                  tmb_pkg::OP_START, tmb_pkg::OP_STOP, tmb_pkg::OP_FREE,
                  tmb_pkg::OP_SET_IVL, tmb_pkg::OP_QUERY, tmb_pkg::OP_TICK: begin
                     state_in = tmb_pkg::S_SCAN;
                  end
                  default: state_in = tmb_pkg::S_DONE;
               endcase
            end
         end
         tmb_pkg::S_SCAN: begin
            if (step && k_ff == LAST_K) state_in = tmb_pkg::S_DONE;
         end
         tmb_pkg::S_DONE: begin
            if (out_free) state_in = tmb_pkg::S_IDLE;
         end
         default: state_in = tmb_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      step = 1'b0;
      wb = head;
      k_in = k_ff;
      op_in = op_ff;
      ti_in = ti_ff;
      iv_in = iv_ff;
      found_in = found_ff;
      now_in = now_ff;
      created_in = created_ff;
      running_in = running_ff;
      fires_in = fires_ff;
      stat_en_in = csr_wr ? pwdata[0] : stat_en_ff;
      rep_status_in = rep_status_ff;
      rep_kind_in = rep_kind_ff;
      rep_index_in = rep_index_ff;
      rep_active_in = rep_active_ff;
      rep_value_in = rep_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_active_in = rsp_active_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         tmb_pkg::S_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               ti_in = req_timer_index;
               iv_in = req_interval_us;
               found_in = 1'b0;
               k_in = '0;
               rep_status_in = tmb_pkg::ST_OK;
               rep_kind_in = tmb_pkg::EV_REPLY;
               rep_index_in = 4'd0;
               rep_active_in = 1'b0;
               rep_value_in = 64'd0;
               case (req_opcode)
                  tmb_pkg::OP_ALLOC_PER, tmb_pkg::OP_ALLOC_ONE: begin
                     rep_status_in = (req_interval_us == 32'd0) ? tmb_pkg::ST_ZERO_IVL
                                                                : tmb_pkg::ST_NO_SLOT;
                  end
                  tmb_pkg::OP_START, tmb_pkg::OP_STOP, tmb_pkg::OP_FREE,
                  tmb_pkg::OP_SET_IVL, tmb_pkg::OP_QUERY: begin
                     // stays "not allocated" unless the scan meets the slot
                     rep_status_in = tmb_pkg::ST_NOT_ALLOC;
                     rep_index_in = req_timer_index;
                  end
                  tmb_pkg::OP_TICK: begin
                     rep_kind_in = tmb_pkg::EV_TICK;
                     now_in = now_ff + 64'(req_advance_us);
                  end
                  tmb_pkg::OP_READ_STAT: begin
                     case (req_stat_select)
                        tmb_pkg::SEL_CREATED: rep_value_in = 64'(created_ff);
                        tmb_pkg::SEL_RUNNING: rep_value_in = 64'(running_ff);
                        tmb_pkg::SEL_FIRES:   rep_value_in = 64'(fires_ff);
                        default:              rep_value_in = 64'd0;
                     endcase
                  end
                  tmb_pkg::OP_CLEAR_STAT: begin
                     created_in = 32'd0;
                     running_in = 5'd0;
                     fires_in = 32'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tmb_pkg::S_SCAN: begin
            step = 1'b1;
            case (op_ff)
               tmb_pkg::OP_ALLOC_PER, tmb_pkg::OP_ALLOC_ONE: begin
                  // take the first free slot in index order
                  if (!found_ff && !head.allocated) begin
                     wb.allocated = 1'b1;
                     wb.running = 1'b0;
                     wb.periodic = (op_ff == tmb_pkg::OP_ALLOC_PER);
                     wb.interval = iv_ff;
                     wb.deadline = 64'd0;
                     found_in = 1'b1;
                     rep_status_in = tmb_pkg::ST_OK;
                     rep_index_in = 4'(k_ff);
                     if (stat_en_ff) created_in = created_ff + 32'd1;
                  end
               end
               tmb_pkg::OP_START: begin
                  if (hit) begin
                     wb.deadline = now_ff + 64'(head.interval);
                     wb.running = 1'b1;
                     rep_status_in = tmb_pkg::ST_OK;
                     if (!head.running && stat_en_ff && running_ff < tmb_pkg::RUN_MAX)
                        running_in = running_ff + 5'd1;
                  end
               end
               tmb_pkg::OP_STOP, tmb_pkg::OP_FREE: begin
                  if (hit) begin
                     wb.running = 1'b0;
                     if (op_ff == tmb_pkg::OP_FREE) wb.allocated = 1'b0;
                     rep_status_in = tmb_pkg::ST_OK;
                     if (head.running && stat_en_ff && running_ff != 5'd0)
                        running_in = running_ff - 5'd1;
                  end
               end
               tmb_pkg::OP_SET_IVL: begin
                  if (hit) begin
                     if (iv_ff == 32'd0) begin
                        rep_status_in = tmb_pkg::ST_ZERO_IVL;
                     end else begin
                        rep_status_in = tmb_pkg::ST_OK;
                        wb.interval = iv_ff;
                        if (head.running) wb.deadline = now_ff + 64'(iv_ff);
                     end
                  end
               end
               tmb_pkg::OP_QUERY: begin
                  if (hit) begin
                     rep_status_in = tmb_pkg::ST_OK;
                     rep_active_in = head.running;
                     if (head.running && head.deadline > now_ff)
                        rep_value_in = head.deadline - now_ff;
                  end
               end
               tmb_pkg::OP_TICK: begin
                  if (due) begin
                     // hold the ring until the result register is free
                     step = out_free;
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = tmb_pkg::ST_OK;
                        rsp_kind_in = tmb_pkg::EV_FIRED;
                        rsp_index_in = 4'(k_ff);
                        rsp_active_in = 1'b0;
                        rsp_value_in = 64'd0;
                        rsp_last_in = 1'b0;
                        if (stat_en_ff) fires_in = fires_ff + 32'd1;
                        if (head.periodic) begin
                           wb.deadline = now_ff + 64'(head.interval);
                        end else begin
                           wb.running = 1'b0;
                           if (stat_en_ff && running_ff != 5'd0)
                              running_in = running_ff - 5'd1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
            // advance the slot counter, wrapping after the last slot
            if (step) k_in = (k_ff == LAST_K) ? '0 : k_ff + IDX_W'(1);
         end
         tmb_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = rep_status_ff;
               rsp_kind_in = rep_kind_ff;
               rsp_index_in = rep_index_ff;
               rsp_active_in = rep_active_ff;
               rsp_value_in = rep_value_ff;
               rsp_last_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmb_pkg::S_IDLE;
         k_ff <= '0;
         found_ff <= 1'b0;
         now_ff <= 64'd0;
         created_ff <= 32'd0;
         running_ff <= 5'd0;
         fires_ff <= 32'd0;
         stat_en_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         found_ff <= found_in;
         now_ff <= now_in;
         created_ff <= created_in;
         running_ff <= running_in;
         fires_ff <= fires_in;
         stat_en_ff <= stat_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ti_ff <= ti_in;
      iv_ff <= iv_in;
      rep_status_ff <= rep_status_in;
      rep_kind_ff <= rep_kind_in;
      rep_index_ff <= rep_index_in;
      rep_active_ff <= rep_active_in;
      rep_value_ff <= rep_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_active_ff <= rsp_active_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_is_active = rsp_active_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;
   assign prdata = {31'd0, stat_en_ff};
   assign pready = 1'b1;

   // the ring is aligned (head holds slot 0) whenever no command runs
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmb_pkg::S_IDLE) |-> (k_ff == '0))
      else $error("slot ring not aligned at idle");

   // a fired beat never closes a tick
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == tmb_pkg::EV_FIRED) |-> !rsp_last_ff)
      else $error("fired beat marked last");

   // the ring only holds during a scan when a fire meets a full result register
   a_hold_reason: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmb_pkg::S_SCAN && !step) |-> (rsp_valid_ff && !rsp_ready))
      else $error("scan stalled without back-pressure");

   // a pending result beat is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_value_ff) && $stable(rsp_kind_ff)))
      else $error("pending result beat changed");
endmodule
